/* sv/bsds_pkg.sv */
// ---------------------------------------------------------------------------
// bsds_pkg
// shared types and constants for the direct biot-savart summation core
// ---------------------------------------------------------------------------
package bsds_pkg;

	// round(2^32 / (4*pi))
	localparam logic [28:0] K_INV4PI = 29'h145F306E;

	// largest |r'| component lies in [2^19, 2^20)
	localparam int RP_BITS   = 20;
	localparam logic [15:0] SKIP_MAX = 16'hFFFF;

	// configuration register indexes
	localparam logic [1:0] REG_TARGET_X = 2'd0;
	localparam logic [1:0] REG_TARGET_Y = 2'd1;
	localparam logic [1:0] REG_TARGET_Z = 2'd2;

	// one classified source handed from the front to the engine
	typedef struct packed {
		logic signed [20:0] rp_x;
		logic signed [20:0] rp_y;
		logic signed [20:0] rp_z;
		logic signed [31:0] s_x;
		logic signed [31:0] s_y;
		logic signed [31:0] s_z;
		logic signed [5:0]  k;
		logic               zero;
		logic               last;
	} bsds_src_t;

endpackage

/* sv/bsds_front.sv */
// ---------------------------------------------------------------------------
// bsds_front
// forms r = target - source, classifies zero distance and normalizes r
// ---------------------------------------------------------------------------
module bsds_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         target_x,
	input  logic [31:0]         target_y,
	input  logic [31:0]         target_z,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         src_x,
	input  logic [31:0]         src_y,
	input  logic [31:0]         src_z,
	input  logic [31:0]         strength_x,
	input  logic [31:0]         strength_y,
	input  logic [31:0]         strength_z,
	input  logic                last_source,
	output logic                push,
	output bsds_pkg::bsds_src_t push_data,
	input  logic                full
);
	import bsds_pkg::*;

	logic [31:0] tgt [0:2];
	logic [31:0] src [0:2];
	logic [31:0] str [0:2];

	logic               en;
	logic               v_s1, v_s2, v_s3;
	logic signed [32:0] r_s1 [0:2];
	logic [31:0]        str_s1 [0:2];
	logic               last_s1;
	logic [32:0]        a_s2 [0:2];
	logic               neg_s2 [0:2];
	logic [31:0]        str_s2 [0:2];
	logic               last_s2;
	logic [32:0]        a_s3 [0:2];
	logic               neg_s3 [0:2];
	logic [31:0]        str_s3 [0:2];
	logic               last_s3;
	logic [5:0]         b_s3;

	logic [32:0]        m;
	logic [5:0]         blen;
	logic signed [5:0]  k;
	logic [32:0]        shv [0:2];
	logic signed [20:0] rp [0:2];

	assign tgt[0] = target_x;
	assign tgt[1] = target_y;
	assign tgt[2] = target_z;
	assign src[0] = src_x;
	assign src[1] = src_y;
	assign src[2] = src_z;
	assign str[0] = strength_x;
	assign str[1] = strength_y;
	assign str[2] = strength_z;

	assign en       = !v_s3 || !full;
	assign in_ready = en;
	assign push     = v_s3 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				r_s1[i]   <= $signed({tgt[i][31], tgt[i]}) - $signed({src[i][31], src[i]});
				str_s1[i] <= str[i];
				a_s2[i]   <= r_s1[i][32] ? 33'(-r_s1[i]) : 33'(r_s1[i]);
				neg_s2[i] <= r_s1[i][32];
				str_s2[i] <= str_s1[i];
				a_s3[i]   <= a_s2[i];
				neg_s3[i] <= neg_s2[i];
				str_s3[i] <= str_s2[i];
			end
			last_s1 <= last_source;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			b_s3    <= blen;
		end
	end

	// largest magnitude and its bit length
	always_comb begin
		m = a_s2[0];
		if (a_s2[1] > m) m = a_s2[1];
		if (a_s2[2] > m) m = a_s2[2];
		blen = '0;
		for (int i = 0; i < 33; i++) begin
			if (m[i]) blen = 6'(i + 1);
		end
	end

	// shift so the largest component has RP_BITS bits
	always_comb begin
		k = $signed(b_s3 - 6'(RP_BITS));
		for (int i = 0; i < 3; i++) begin
			if (!k[5]) shv[i] = a_s3[i] >> k;
			else       shv[i] = a_s3[i] << 6'(-k);
			rp[i] = neg_s3[i] ? -$signed({1'b0, shv[i][RP_BITS-1:0]})
			                  :  $signed({1'b0, shv[i][RP_BITS-1:0]});
		end
	end

	always_comb begin
		push_data.rp_x = rp[0];
		push_data.rp_y = rp[1];
		push_data.rp_z = rp[2];
		push_data.s_x  = $signed(str_s3[0]);
		push_data.s_y  = $signed(str_s3[1]);
		push_data.s_z  = $signed(str_s3[2]);
		push_data.k    = k;
		push_data.zero = (b_s3 == 6'd0);
		push_data.last = last_s3;
	end

endmodule

/* sv/bsds_fifo.sv */
// ---------------------------------------------------------------------------
// bsds_fifo
// short queue of classified sources between front and engine
// ---------------------------------------------------------------------------
module bsds_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  bsds_pkg::bsds_src_t wr_data,
	output logic                full,
	input  logic                rd_en,
	output bsds_pkg::bsds_src_t rd_data,
	output logic                empty
);
	import bsds_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	bsds_src_t     mem [0:DEPTH-1];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign full    = (cnt_q == (PW + 1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd_en) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (wr_en && !rd_en)      cnt_q <= cnt_q + 1'b1;
			else if (!wr_en && rd_en) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* sv/bsds_engine.sv */
// ---------------------------------------------------------------------------
// bsds_engine
// per-source term: cross product, isqrt, divide, saturating accumulate
// ---------------------------------------------------------------------------
module bsds_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fifo_empty,
	output logic                fifo_pop,
	input  bsds_pkg::bsds_src_t fifo_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         vel_x,
	output logic [63:0]         vel_y,
	output logic [63:0]         vel_z,
	output logic                saturated,
	output logic [15:0]         coincident_count
);
	import bsds_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_SQRT = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_MAG  = 3'd5;
	localparam logic [2:0] ST_ACC  = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	localparam logic [63:0] ACC_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	logic [2:0]  state_q;
	logic [5:0]  step_q;
	bsds_src_t   ent_q;

	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_q;
	logic signed [53:0] c_q [0:2];
	logic [41:0] d_q, d_nx;
	logic [63:0] sv_q, rt_q, bit_q, rb;
	logic [63:0] den_q;
	logic [80:0] num_q [0:2];
	logic [63:0] rem_q [0:2];
	logic [63:0] nsh_q [0:2];
	logic [63:0] quo_q [0:2];
	logic [64:0] trial [0:2];
	logic [63:0] mag_q [0:2];
	logic        big_q [0:2];
	logic [63:0] mag_nx [0:2];
	logic        big_nx [0:2];
	logic [52:0] ca [0:2];
	logic signed [7:0] e;
	logic [5:0]  shr;
	logic [3:0]  shl;

	logic [63:0] acc_q [0:2];
	logic [63:0] acc_nx [0:2];
	logic        sat_nx [0:2];
	logic        sat_q;
	logic [15:0] skip_q;
	logic        out_valid_q;
	logic        load_out;
	logic [63:0] vel_q [0:2];
	logic        osat_q;
	logic [15:0] ocnt_q;

	logic signed [20:0] rp [0:2];
	logic signed [31:0] sv [0:2];

	assign rp[0] = ent_q.rp_x;
	assign rp[1] = ent_q.rp_y;
	assign rp[2] = ent_q.rp_z;
	assign sv[0] = ent_q.s_x;
	assign sv[1] = ent_q.s_y;
	assign sv[2] = ent_q.s_z;

	assign fifo_pop = (state_q == ST_IDLE) && !fifo_empty;
	assign load_out = (state_q == ST_FIN) && ent_q.last && (!out_valid_q || out_ready);

	assign out_valid        = out_valid_q;
	assign vel_x            = vel_q[0];
	assign vel_y            = vel_q[1];
	assign vel_z            = vel_q[2];
	assign saturated        = osat_q;
	assign coincident_count = ocnt_q;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			ca[j] = c_q[j][53] ? 53'(-c_q[j]) : 53'(c_q[j]);
		end
	end

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		if (state_q == ST_MUL1) begin
			case (step_q)
			6'd0: begin ma = 33'(rp[1]); mb = 33'(sv[2]); end
			6'd1: begin ma = 33'(rp[2]); mb = 33'(sv[1]); end
			6'd2: begin ma = 33'(rp[2]); mb = 33'(sv[0]); end
			6'd3: begin ma = 33'(rp[0]); mb = 33'(sv[2]); end
			6'd4: begin ma = 33'(rp[0]); mb = 33'(sv[1]); end
			6'd5: begin ma = 33'(rp[1]); mb = 33'(sv[0]); end
			6'd6: begin ma = 33'(rp[0]); mb = 33'(rp[0]); end
			6'd7: begin ma = 33'(rp[1]); mb = 33'(rp[1]); end
			6'd8: begin ma = 33'(rp[2]); mb = 33'(rp[2]); end
			default: begin ma = '0; mb = '0; end
			endcase
		end else if (state_q == ST_MUL2) begin
			case (step_q)
			6'd0: begin ma = $signed({1'b0, d_q[41:10]}); mb = $signed({1'b0, rt_q[31:0]}); end
			6'd1: begin ma = $signed({7'b0, ca[0][25:0]}); mb = $signed({4'b0, K_INV4PI}); end
			6'd2: begin ma = $signed({7'b0, ca[0][51:26]}); mb = $signed({4'b0, K_INV4PI}); end
			6'd3: begin ma = $signed({7'b0, ca[1][25:0]}); mb = $signed({4'b0, K_INV4PI}); end
			6'd4: begin ma = $signed({7'b0, ca[1][51:26]}); mb = $signed({4'b0, K_INV4PI}); end
			6'd5: begin ma = $signed({7'b0, ca[2][25:0]}); mb = $signed({4'b0, K_INV4PI}); end
			6'd6: begin ma = $signed({7'b0, ca[2][51:26]}); mb = $signed({4'b0, K_INV4PI}); end
			default: begin ma = '0; mb = '0; end
			endcase
		end
	end

	assign d_nx = d_q + prod_q[41:0];
	assign rb   = rt_q + bit_q;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			trial[j] = {rem_q[j], nsh_q[j][63]};
		end
	end

	// final scale by 2^(17 - 2k - 40)
	always_comb begin
		e   = 8'sd17 - ({{2{ent_q.k[5]}}, ent_q.k} <<< 1);
		shr = 6'(8'sd40 - e);
		shl = 4'(e - 8'sd40);
		for (int j = 0; j < 3; j++) begin
			if (e <= 8'sd40) begin
				mag_nx[j] = quo_q[j] >> shr;
				big_nx[j] = 1'b0;
			end else begin
				mag_nx[j] = quo_q[j] << shl;
				big_nx[j] = (quo_q[j] >> (7'd64 - 7'(shl))) != 64'd0;
			end
		end
	end

	// saturating subtract of the signed term
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			acc_nx[j] = acc_q[j];
			sat_nx[j] = 1'b0;
			if (c_q[j] != '0 && (mag_q[j] != '0 || big_q[j])) begin
				if (!c_q[j][53]) begin
					if (big_q[j] || mag_q[j] > (acc_q[j] ^ ACC_MIN)) begin
						acc_nx[j] = ACC_MIN;
						sat_nx[j] = 1'b1;
					end else begin
						acc_nx[j] = acc_q[j] - mag_q[j];
					end
				end else begin
					if (big_q[j] || mag_q[j] > ~(acc_q[j] ^ ACC_MIN)) begin
						acc_nx[j] = ACC_MAX;
						sat_nx[j] = 1'b1;
					end else begin
						acc_nx[j] = acc_q[j] + mag_q[j];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			sat_q       <= 1'b0;
			skip_q      <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < 3; j++) acc_q[j] <= '0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
			ST_IDLE: begin
				if (!fifo_empty) begin
					step_q <= '0;
					if (fifo_data.zero) begin
						if (skip_q != SKIP_MAX) skip_q <= skip_q + 1'b1;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_MUL1;
					end
				end
			end
			ST_MUL1: begin
				if (step_q == 6'd9) begin
					step_q  <= '0;
					state_q <= ST_SQRT;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			ST_SQRT: begin
				if (step_q == 6'd31) begin
					step_q  <= '0;
					state_q <= ST_MUL2;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			ST_MUL2: begin
				if (step_q == 6'd8) begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			ST_DIV: begin
				if (step_q == 6'd63) state_q <= ST_MAG;
				step_q <= step_q + 1'b1;
			end
			ST_MAG: state_q <= ST_ACC;
			ST_ACC: begin
				for (int j = 0; j < 3; j++) acc_q[j] <= acc_nx[j];
				sat_q   <= sat_q | sat_nx[0] | sat_nx[1] | sat_nx[2];
				state_q <= ST_FIN;
			end
			ST_FIN: begin
				if (!ent_q.last) begin
					state_q <= ST_IDLE;
				end else if (load_out) begin
					for (int j = 0; j < 3; j++) acc_q[j] <= '0;
					sat_q   <= 1'b0;
					skip_q  <= '0;
					state_q <= ST_IDLE;
				end
			end
			default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		if (fifo_pop) ent_q <= fifo_data;
		case (state_q)
		ST_MUL1: begin
			case (step_q)
			6'd1: c_q[0] <= prod_q[53:0];
			6'd2: c_q[0] <= c_q[0] - prod_q[53:0];
			6'd3: c_q[1] <= prod_q[53:0];
			6'd4: c_q[1] <= c_q[1] - prod_q[53:0];
			6'd5: c_q[2] <= prod_q[53:0];
			6'd6: c_q[2] <= c_q[2] - prod_q[53:0];
			6'd7: d_q <= prod_q[41:0];
			6'd8: d_q <= d_nx;
			6'd9: begin
				d_q   <= d_nx;
				sv_q  <= {d_nx, 22'b0};
				rt_q  <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			default: d_q <= d_q;
			endcase
		end
		ST_SQRT: begin
			if (sv_q >= rb) begin
				sv_q <= sv_q - rb;
				rt_q <= (rt_q >> 1) + bit_q;
			end else begin
				rt_q <= rt_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		ST_MUL2: begin
			case (step_q)
			6'd1: den_q <= prod_q[63:0];
			6'd2: num_q[0] <= 81'(prod_q[54:0]);
			6'd3: num_q[0] <= num_q[0] + {prod_q[54:0], 26'b0};
			6'd4: num_q[1] <= 81'(prod_q[54:0]);
			6'd5: num_q[1] <= num_q[1] + {prod_q[54:0], 26'b0};
			6'd6: num_q[2] <= 81'(prod_q[54:0]);
			6'd7: num_q[2] <= num_q[2] + {prod_q[54:0], 26'b0};
			6'd8: begin
				for (int j = 0; j < 3; j++) begin
					rem_q[j] <= 64'(num_q[j][80:24]);
					nsh_q[j] <= {num_q[j][23:0], 40'b0};
					quo_q[j] <= '0;
				end
			end
			default: den_q <= den_q;
			endcase
		end
		ST_DIV: begin
			for (int j = 0; j < 3; j++) begin
				if (trial[j] >= {1'b0, den_q}) begin
					rem_q[j] <= 64'(trial[j] - {1'b0, den_q});
					quo_q[j] <= {quo_q[j][62:0], 1'b1};
				end else begin
					rem_q[j] <= trial[j][63:0];
					quo_q[j] <= {quo_q[j][62:0], 1'b0};
				end
				nsh_q[j] <= nsh_q[j] << 1;
			end
		end
		ST_MAG: begin
			for (int j = 0; j < 3; j++) begin
				mag_q[j] <= mag_nx[j];
				big_q[j] <= big_nx[j];
			end
		end
		default: den_q <= den_q;
		endcase
		if (load_out) begin
			for (int j = 0; j < 3; j++) vel_q[j] <= acc_q[j];
			osat_q <= sat_q;
			ocnt_q <= skip_q;
		end
	end

	// integer square root never exceeds the floor
	a_sqrt_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL2 && step_q == 6'd0) |->
		(64'(rt_q[31:0]) * 64'(rt_q[31:0]) <= {d_q, 22'b0}))
		else $error("isqrt result too large");

	// divider remainder stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |->
		(rem_q[0] < den_q && rem_q[1] < den_q && rem_q[2] < den_q))
		else $error("divider remainder out of range");

	// accumulators move only on update or run end
	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ACC && state_q != ST_FIN) |=>
		($stable(acc_q[0]) && $stable(acc_q[1]) && $stable(acc_q[2])))
		else $error("accumulator changed outside update");

	// a result appears only at run end
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN && ent_q.last))
		else $error("result raised outside run end");

endmodule

/* sv/biot_savart_direct_summation_core.sv */
// ---------------------------------------------------------------------------
// biot_savart_direct_summation_core
// direct biot-savart velocity sum at one evaluation point over a source stream
// ---------------------------------------------------------------------------
//  channel   | dir | contents
//  s_axis    | in  | tdata: src x/y/z, strength x/y/z (q16.16); tlast ends run
//  m_axis    | out | tdata: vel x/y/z (q32.32), saturated, coincident_count
//  apb       | in  | target_x/y/z at byte offsets 0x0, 0x4, 0x8
//
//  a source word in the engine is popped, then runs on the shared 33x33
//  multiplier for cross product and |r'|^2, the bit-serial isqrt, the
//  denominator and numerator products and the three radix-2 dividers that
//  run side by side, then scale, accumulate, finish
//  a source at zero distance is counted and goes from the pop straight to finish
//  the front takes a word per cycle into a 3-stage pipeline and a queue of
//  QUEUE_DEPTH entries; it stalls only when the queue is full
//  reset clears the targets, accumulators, flags, queue and result valid flag
//  a finished result waits in its register; only the next run end stalls on it
// ---------------------------------------------------------------------------
module biot_savart_direct_summation_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	// apb configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// source words
	input  logic         s_tvalid,
	output logic         s_tready,
	// src_x, src_y, src_z, strength_x, strength_y, strength_z
	input  logic [191:0] s_tdata,
	// last_source
	input  logic         s_tlast,
	// result words
	output logic         m_tvalid,
	input  logic         m_tready,
	// vel_x, vel_y, vel_z, saturated, coincident_count, zero pad
	output logic [215:0] m_tdata
);
	import bsds_pkg::*;

	logic [31:0] target_x_q, target_y_q, target_z_q;
	logic        cfg_wr;

	logic      push, full, pop, empty;
	bsds_src_t push_data, pop_data;

	logic [63:0] vel_x, vel_y, vel_z;
	logic        saturated;
	logic [15:0] coincident_count;

	// register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= '0;
			target_y_q <= '0;
			target_z_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
			REG_TARGET_X: target_x_q <= pwdata;
			REG_TARGET_Y: target_y_q <= pwdata;
			REG_TARGET_Z: target_z_q <= pwdata;
			default: target_x_q <= target_x_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
		REG_TARGET_X: prdata = target_x_q;
		REG_TARGET_Y: prdata = target_y_q;
		REG_TARGET_Z: prdata = target_z_q;
		default:      prdata = '0;
		endcase
	end

	// front: difference, zero check, normalize
	bsds_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.target_x    (target_x_q),
		.target_y    (target_y_q),
		.target_z    (target_z_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.src_x       (s_tdata[31:0]),
		.src_y       (s_tdata[63:32]),
		.src_z       (s_tdata[95:64]),
		.strength_x  (s_tdata[127:96]),
		.strength_y  (s_tdata[159:128]),
		.strength_z  (s_tdata[191:160]),
		.last_source (s_tlast),
		.push        (push),
		.push_data   (push_data),
		.full        (full)
	);

	// decouples front and engine
	bsds_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (push_data),
		.full    (full),
		.rd_en   (pop),
		.rd_data (pop_data),
		.empty   (empty)
	);

	// back: per-source term and accumulation
	bsds_engine u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.fifo_empty       (empty),
		.fifo_pop         (pop),
		.fifo_data        (pop_data),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.vel_x            (vel_x),
		.vel_y            (vel_y),
		.vel_z            (vel_z),
		.saturated        (saturated),
		.coincident_count (coincident_count)
	);

	assign m_tdata = {7'b0, coincident_count, saturated, vel_z, vel_y, vel_x};

endmodule

/* test/tb.sv */
// ---------------------------------------------------------------------------
// tb
// source stream test of the biot-savart summation core against an own model
// of the fixed-point kernel: directed corner runs, random runs per target
// setting, a long receiver hold-off and a run of coincident sources only
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bsds_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int HOLD_CYCLES    = 3000;

	typedef struct {
		logic [31:0] src [3];
		logic [31:0] str [3];
		logic        last;
	} source_t;

	typedef struct {
		logic [63:0] vel [3];
		logic        sat;
		logic [15:0] skips;
	} velocity_t;

	typedef struct {
		source_t   s;
		logic      typed;
		velocity_t v;
	} stim_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// src_x, src_y, src_z, strength_x, strength_y, strength_z
	logic [191:0] s_tdata = '0;
	// last_source
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// vel_x, vel_y, vel_z, saturated, coincident_count, zero pad
	logic [215:0] m_tdata;

	biot_savart_direct_summation_core i_dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast, .m_tvalid, .m_tready, .m_tdata
	);

	always #10 clk = ~clk;

	// model state: evaluation point, accumulators, flags
	logic [31:0] target [3];
	logic [63:0] vel_acc [3];
	logic        sat_seen;
	int unsigned skip_cnt;

	velocity_t   expected_vel [$];
	stim_row_t   directed [$];
	int          errors = 0;
	int          n_sources = 0, n_results = 0, n_coincident = 0, n_sat_runs = 0;
	bit          quiet = 0;
	bit          hold_req = 0;
	int          idle_cycles = 0;

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	// subtract sign(c)*mag from one accumulator, saturating at the 64-bit limits
	function automatic void acc_sub(input int i, input longint c, input logic [63:0] mag,
			input bit big);
		logic [63:0] room;
		if (c == 0 || (mag == 0 && !big)) return;
		if (c > 0) begin
			room = vel_acc[i] ^ 64'h8000_0000_0000_0000;
			if (big || mag > room) begin
				vel_acc[i] = 64'h8000_0000_0000_0000;
				sat_seen = 1;
			end else vel_acc[i] -= mag;
		end else begin
			room = 64'h7FFF_FFFF_FFFF_FFFF - vel_acc[i];
			if (big || mag > room) begin
				vel_acc[i] = 64'h7FFF_FFFF_FFFF_FFFF;
				sat_seen = 1;
			end else vel_acc[i] += mag;
		end
	endfunction

	// one kernel term: normalize r, cross product, 1/(4 pi |r|^3) scaling
	function automatic void add_term(input longint r [3], input longint s [3]);
		longint      rp [3], c [3];
		logic [63:0] m, a, d, q, den, qq, mag;
		logic [127:0] num;
		int          b, k, e, sh;
		bit          big;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			a = r[i] < 0 ? -r[i] : r[i];
			if (a > m) m = a;
		end
		b = 0;
		while (b < 64 && (m >> b) != 0) b++;
		k = b - RP_BITS;
		for (int i = 0; i < 3; i++) begin
			a = r[i] < 0 ? -r[i] : r[i];
			a = (k >= 0) ? (a >> k) : (a << (-k));
			rp[i] = r[i] < 0 ? -longint'(a) : longint'(a);
		end
		c[0] = rp[1] * s[2] - rp[2] * s[1];
		c[1] = rp[2] * s[0] - rp[0] * s[2];
		c[2] = rp[0] * s[1] - rp[1] * s[0];
		d = rp[0] * rp[0] + rp[1] * rp[1] + rp[2] * rp[2];
		q = isqrt(d << 22);
		den = (d >> 10) * q;
		e = 17 - 2 * k;
		for (int i = 0; i < 3; i++) begin
			a = c[i] < 0 ? -c[i] : c[i];
			num = (128'(a) * 128'(K_INV4PI)) << 40;
			qq = 64'(num / 128'(den));
			big = 0;
			if (e <= 40) mag = qq >> (40 - e);
			else begin
				sh = e - 40;
				if (qq > (64'hFFFF_FFFF_FFFF_FFFF >> sh)) begin
					big = 1;
					mag = '1;
				end else mag = qq << sh;
			end
			acc_sub(i, c[i], mag, big);
		end
	endfunction

	// advance the model by one source; returns 1 with the velocity on a run end
	function automatic bit sum_source(input source_t it, output velocity_t v);
		longint r [3], s [3];
		for (int i = 0; i < 3; i++) begin
			r[i] = longint'($signed(target[i])) - longint'($signed(it.src[i]));
			s[i] = longint'($signed(it.str[i]));
		end
		if (r[0] == 0 && r[1] == 0 && r[2] == 0) begin
			if (skip_cnt < 65535) skip_cnt++;
		end else add_term(r, s);
		if (!it.last) return 0;
		v.vel = vel_acc;
		v.sat = sat_seen;
		v.skips = 16'(skip_cnt);
		vel_acc = '{3{64'd0}};
		sat_seen = 0;
		skip_cnt = 0;
		return 1;
	endfunction

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		target[idx] = val;
	endtask

	// block is idle only when every result is back and the engine has drained
	task automatic set_target(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		wait_drained();
		apb_write(REG_TARGET_X, x);
		apb_write(REG_TARGET_Y, y);
		apb_write(REG_TARGET_Z, z);
	endtask

	task automatic wait_drained();
		while (expected_vel.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// offer one source word, with random gaps unless in a quiet stretch
	task automatic send_source(input source_t it, input bit typed, input velocity_t tv);
		velocity_t v;
		while (!quiet && $urandom_range(0, 99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {it.str[2], it.str[1], it.str[0], it.src[2], it.src[1], it.src[0]};
		s_tlast <= it.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_sources++;
		if (sum_source(it, v)) expected_vel.push_back(typed ? tv : v);
	endtask

	task automatic add_row(input logic [31:0] sx, sy, sz, input logic [31:0] tx, ty, tz,
			input logic last, input bit typed, input logic [63:0] vx, vy, vz,
			input logic sat, input logic [15:0] skips);
		stim_row_t row;
		row.s.src = '{sx, sy, sz};
		row.s.str = '{tx, ty, tz};
		row.s.last = last;
		row.typed = typed;
		row.v.vel = '{vx, vy, vz};
		row.v.sat = sat;
		row.v.skips = skips;
		directed.push_back(row);
	endtask

	// random source: coincident, close to the target, or anywhere
	function automatic source_t rand_source(input bit last);
		source_t it;
		int      kind;
		kind = $urandom_range(0, 99);
		for (int i = 0; i < 3; i++) begin
			if (kind < 6) it.src[i] = target[i];
			else if (kind < 40) it.src[i] = target[i] + 32'($signed($urandom_range(0, 8191)) - 4096)
					* (32'd1 << $urandom_range(0, 12));
			else it.src[i] = $urandom;
			it.str[i] = $urandom_range(0, 1) ? $urandom : 32'($signed(20'($urandom)));
		end
		it.last = last;
		return it;
	endfunction

	task automatic random_runs(input int n_items);
		int left, run;
		left = n_items;
		while (left > 0) begin
			run = $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 6);
			for (int j = 0; j < run; j++) send_source(rand_source(j == run - 1), 0, '{default: '0});
			left -= run;
		end
	endtask

	// result checker: compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		velocity_t exp_v;
		logic [63:0] got [3];
		if (m_tvalid && m_tready) begin
			got = '{m_tdata[63:0], m_tdata[127:64], m_tdata[191:128]};
			if (expected_vel.size() == 0) begin
				$display("%0t: result word with none expected, tdata=%h", $time, m_tdata);
				errors++;
			end else begin
				exp_v = expected_vel.pop_front();
				n_results++;
				if (exp_v.sat) n_sat_runs++;
				if (exp_v.skips != 0) n_coincident++;
				for (int i = 0; i < 3; i++)
					if (got[i] !== exp_v.vel[i]) begin
						$display("%0t: vel[%0d] expected %h got %h", $time, i, exp_v.vel[i], got[i]);
						errors++;
					end
				if (m_tdata[192] !== exp_v.sat) begin
					$display("%0t: saturated expected %b got %b", $time, exp_v.sat, m_tdata[192]);
					errors++;
				end
				if (m_tdata[208:193] !== exp_v.skips) begin
					$display("%0t: coincident_count expected %0d got %0d", $time, exp_v.skips,
						m_tdata[208:193]);
					errors++;
				end
				if (m_tdata[215:209] !== '0) begin
					$display("%0t: pad expected 0 got %h", $time, m_tdata[215:209]);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
			idle_cycles <= idle_cycles + 1;
		else
			idle_cycles <= 0;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time, expected_vel.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random backpressure, a quiet stretch, one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= quiet || $urandom_range(0, 99) >= 28;
			end
		end
	end

	initial begin
		source_t it;
		target = '{3{32'd0}};
		vel_acc = '{3{64'd0}};
		sat_seen = 0;
		skip_cnt = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, targets still at their reset value of zero
		// coincident source ending a run: nothing summed, one skip
		add_row(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 1, 0, 0, 0, 0, 16'd1);
		// zero strength contributes nothing
		add_row(32'h0001_0000, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 16'd0);
		// far extremes of position and strength
		add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1,
			0, 0, 0, 0, 0, 0, 0);
		add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 1, 0, 0, 0, 0, 0, 0);
		// one lsb away with full strength: term too large, saturates
		add_row(1, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, 0, 1, 2, 3, 0, 0, 0, 0, 0, 0, 0);
		add_row(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			1, 0, 0, 0, 0, 0, 0);
		// unit geometry and a short mixed run
		add_row(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 1, 0, 0, 0, 0, 0, 0);
		add_row(0, 32'h0002_0000, 0, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, 32'hFFFF_0000, 0, 32'hFFFF_8000, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0003_0000, 32'hFFFD_0000,
			32'h1234_5678, 0, 0, 0, 0, 0, 0, 0);
		add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF,
			1, 0, 0, 0, 0, 0, 0);
		foreach (directed[i]) send_source(directed[i].s, directed[i].typed, directed[i].v);
		s_tvalid <= 1'b0;

		// random runs over several evaluation points, extremes included
		set_target($urandom, $urandom, $urandom);
		random_runs(400);
		s_tvalid <= 1'b0;

		set_target(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		hold_req = 1;
		random_runs(400);
		s_tvalid <= 1'b0;

		set_target(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		quiet = 1;
		random_runs(300);
		quiet = 0;
		s_tvalid <= 1'b0;

		set_target(32'h8000_0000, 32'h7FFF_FFFF, 0);
		random_runs(300);
		s_tvalid <= 1'b0;

		set_target($urandom, 32'h0001_0000, $urandom);
		random_runs(320);
		s_tvalid <= 1'b0;

		// a run of coincident sources only: nothing summed, every one counted
		wait_drained();
		quiet = 1;
		for (int j = 0; j < 30; j++) begin
			it.src = target;
			it.str = '{$urandom, $urandom, $urandom};
			it.last = (j == 29);
			send_source(it, 0, '{default: '0});
		end
		quiet = 0;
		s_tvalid <= 1'b0;

		wait_drained();
		$display("summed %0d sources into %0d velocity words", n_sources, n_results);
		$display("runs with skips: %0d, saturated runs: %0d", n_coincident, n_sat_runs);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* biot_savart_direct_summation_core.f */
sv/bsds_pkg.sv
sv/bsds_front.sv
sv/bsds_fifo.sv
sv/bsds_engine.sv
sv/biot_savart_direct_summation_core.sv
test/tb.sv
